FILE: src/tgdm_pkg.sv
package tgdm_pkg;

    localparam int GRID_W = 128;
    localparam int GRID_H = 128;
    localparam int DEPTH  = GRID_W * GRID_H;
    localparam int AW     = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    // coordinate width: holds a 7-bit centre plus a 6-bit radius and any grid index
    localparam int GMAX   = (GRID_W > GRID_H) ? GRID_W : GRID_H;
    localparam int CW     = (($clog2(GMAX) > 7) ? $clog2(GMAX) : 7) + 2;
    localparam int SQ_W   = 2 * CW;

    localparam int TTL_W  = 16;
    localparam int RAD_W  = 6;
    localparam int COST_W = 8;
    localparam int CFG_W  = 16;
    localparam int IDX_W  = 2;

    localparam logic [COST_W-1:0] LETHAL_COST = 8'd254;
    localparam logic [TTL_W-1:0]  TTL_RESET   = 16'd300;
    localparam logic [RAD_W-1:0]  RAD_RESET   = 6'd4;

    localparam logic [IDX_W-1:0] CFG_TTL_MS  = 2'd0;
    localparam logic [IDX_W-1:0] CFG_RADIUS  = 2'd1;
    localparam logic [IDX_W-1:0] CFG_ENABLED = 2'd2;

    typedef enum logic [1:0] {
        REQ_DECAY   = 2'd0,
        REQ_STAMP   = 2'd1,
        REQ_REFRESH = 2'd2,
        REQ_CLEAR   = 2'd3
    } req_t;

    function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] y, input logic [CW-1:0] x);
        logic [AW+CW-1:0] full;
        full = (AW+CW)'(y) * (AW+CW)'(GRID_W) + (AW+CW)'(x);
        return full[AW-1:0];
    endfunction

endpackage

FILE: src/ttl_grid_disk_marker.sv
// Grid of per-cell time-to-live counters with disk stamping.
// Item channel: an item is taken at a clock edge with start high and busy low.
// Every item gives one result, shown for one cycle with done high; the receiver
// cannot stall, so results are never held. Config: cfg_valid/cfg_ready
// (ready always high) with cfg_index and cfg_data; write only while idle.
// Steps per item, from acceptance to the done strobe:
//   refresh             one registered read of the cell memory
//   decay tick          read-modify-write sweep, one cell a cycle
//   clear               write sweep, one cell a cycle
//   stamp               an init step, then per row of the clipped bounding box a row step and a step per cell
//   disabled, zero time or empty stamp: done with no sweep or walk
// The single-port-write cell memory limits sweeps to one cell per cycle; stamp
// cells share one squaring multiplier (r^2 once, dy^2 per row, dx^2 per cell).
// After reset the block runs a clearing pass over all DEPTH (16384) cells with busy
// high and gives no result; config writes are taken meanwhile.
module ttl_grid_disk_marker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [1:0]                     req_type,
    input  logic [6:0]                     cell_x,
    input  logic [6:0]                     cell_y,
    input  logic [tgdm_pkg::TTL_W-1:0]     elapsed_ms,
    input  logic [tgdm_pkg::COST_W-1:0]    master_cost,
    output logic                           done,
    output logic [tgdm_pkg::COST_W-1:0]    master_cost_out,
    output logic                           cell_live,
    output logic                           live_expired,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tgdm_pkg::IDX_W-1:0]     cfg_index,
    input  logic [tgdm_pkg::CFG_W-1:0]     cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_DECAY,
        ST_STAMP_INIT,
        ST_ROW,
        ST_CELL,
        ST_REFRESH
    } state_t;

    localparam int CW   = tgdm_pkg::CW;
    localparam int SQ_W = tgdm_pkg::SQ_W;
    localparam int AW   = tgdm_pkg::AW;

    state_t                          state_reg;
    logic [tgdm_pkg::CNT_W-1:0]      cnt_reg;
    logic                            report_reg;
    logic                            had_reg;
    logic                            after_reg;
    logic [CW-1:0]                   cx_reg, cy_reg;
    logic [CW-1:0]                   x_reg, y_reg;
    logic [CW-1:0]                   x0_reg, x1_reg, y1_reg;
    logic [SQ_W-1:0]                 r2_reg, dy2_reg;
    logic [tgdm_pkg::TTL_W-1:0]      dt_reg;
    logic [tgdm_pkg::COST_W-1:0]     master_reg;
    logic                            in_grid_reg;

    logic                            done_reg;
    logic [tgdm_pkg::COST_W-1:0]     cost_reg;
    logic                            live_reg;
    logic                            expired_reg;

    logic [tgdm_pkg::TTL_W-1:0]      ttl_ms_reg;
    logic [tgdm_pkg::RAD_W-1:0]      radius_reg;
    logic                            enabled_reg;

    logic [tgdm_pkg::TTL_W-1:0]      mem [tgdm_pkg::DEPTH];
    logic [tgdm_pkg::TTL_W-1:0]      rd_data_reg;
    logic                            mem_we;
    logic [AW-1:0]                   mem_waddr;
    logic [AW-1:0]                   mem_raddr;
    logic [tgdm_pkg::TTL_W-1:0]      mem_wdata;

    logic                            accept;
    logic [CW-1:0]                   in_x, in_y;
    logic                            in_grid;
    logic [tgdm_pkg::CNT_W-1:0]      cnt_m1;
    logic [tgdm_pkg::TTL_W-1:0]      dec_val;
    logic                            cell_nz, cell_stays;
    logic [CW-1:0]                   mul_a;
    logic [SQ_W-1:0]                 sq;
    logic                            in_disk;
    logic [CW-1:0]                   rad_ext, x0_calc, x1_calc, y0_calc, y1_calc;
    logic [CW-1:0]                   xs, ys;
    logic                            refresh_live;

    assign busy            = (state_reg != ST_IDLE);
    assign accept          = start && !busy;
    assign cfg_ready       = 1'b1;
    assign done            = done_reg;
    assign master_cost_out = cost_reg;
    assign cell_live       = live_reg;
    assign live_expired    = expired_reg;

    assign in_x    = CW'(cell_x);
    assign in_y    = CW'(cell_y);
    assign in_grid = (in_x < CW'(tgdm_pkg::GRID_W)) && (in_y < CW'(tgdm_pkg::GRID_H));
    assign cnt_m1  = cnt_reg - tgdm_pkg::CNT_W'(1);

    assign dec_val    = (rd_data_reg > dt_reg) ? (rd_data_reg - dt_reg) : '0;
    assign cell_nz    = (rd_data_reg != '0);
    assign cell_stays = (rd_data_reg > dt_reg);

    // bounding box of the disk, clipped to the grid
    assign rad_ext = CW'(radius_reg);
    assign xs      = cx_reg + rad_ext;
    assign ys      = cy_reg + rad_ext;
    assign x0_calc = (cx_reg >= rad_ext) ? (cx_reg - rad_ext) : '0;
    assign y0_calc = (cy_reg >= rad_ext) ? (cy_reg - rad_ext) : '0;
    assign x1_calc = (xs > CW'(tgdm_pkg::GRID_W - 1)) ? CW'(tgdm_pkg::GRID_W - 1) : xs;
    assign y1_calc = (ys > CW'(tgdm_pkg::GRID_H - 1)) ? CW'(tgdm_pkg::GRID_H - 1) : ys;

    // shared squaring unit
    always_comb
    begin
        unique case (state_reg)
            ST_STAMP_INIT: mul_a = rad_ext;
            ST_ROW:        mul_a = (y_reg >= cy_reg) ? (y_reg - cy_reg) : (cy_reg - y_reg);
            ST_CELL:       mul_a = (x_reg >= cx_reg) ? (x_reg - cx_reg) : (cx_reg - x_reg);
            default:       mul_a = '0;
        endcase
    end

    assign sq      = SQ_W'(mul_a) * SQ_W'(mul_a);
    assign in_disk = ((SQ_W+1)'(sq) + (SQ_W+1)'(dy2_reg)) <= (SQ_W+1)'(r2_reg);

    assign refresh_live = in_grid_reg && cell_nz;

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = '0;
        mem_raddr = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                mem_raddr = tgdm_pkg::addr_of(in_y, in_x);
            end
            ST_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = cnt_reg[AW-1:0];
            end
            ST_DECAY:
            begin
                mem_raddr = cnt_reg[AW-1:0];
                mem_we    = (cnt_reg != '0);
                mem_waddr = cnt_m1[AW-1:0];
                mem_wdata = dec_val;
            end
            ST_CELL:
            begin
                mem_we    = in_disk;
                mem_waddr = tgdm_pkg::addr_of(y_reg, x_reg);
                mem_wdata = ttl_ms_reg;
            end
            default:
            begin
                mem_raddr = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        rd_data_reg <= mem[mem_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ttl_ms_reg  <= tgdm_pkg::TTL_RESET;
            radius_reg  <= tgdm_pkg::RAD_RESET;
            enabled_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                tgdm_pkg::CFG_TTL_MS:  ttl_ms_reg  <= cfg_data;
                tgdm_pkg::CFG_RADIUS:  radius_reg  <= cfg_data[tgdm_pkg::RAD_W-1:0];
                tgdm_pkg::CFG_ENABLED: enabled_reg <= cfg_data[0];
                default:               ttl_ms_reg  <= ttl_ms_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            cnt_reg     <= '0;
            report_reg  <= 1'b0;
            had_reg     <= 1'b0;
            after_reg   <= 1'b0;
            done_reg    <= 1'b0;
            cost_reg    <= '0;
            live_reg    <= 1'b0;
            expired_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        cx_reg      <= in_x;
                        cy_reg      <= in_y;
                        dt_reg      <= elapsed_ms;
                        master_reg  <= master_cost;
                        in_grid_reg <= in_grid;
                        cnt_reg     <= '0;
                        had_reg     <= 1'b0;
                        after_reg   <= 1'b0;
                        cost_reg    <= master_cost;
                        live_reg    <= 1'b0;
                        expired_reg <= 1'b0;
                        unique case (tgdm_pkg::req_t'(req_type))
                            tgdm_pkg::REQ_DECAY:
                            begin
                                if (enabled_reg && (elapsed_ms != '0))
                                    state_reg <= ST_DECAY;
                                else
                                    done_reg <= 1'b1;
                            end
                            tgdm_pkg::REQ_STAMP:
                            begin
                                if (enabled_reg && (radius_reg != '0) && in_grid)
                                    state_reg <= ST_STAMP_INIT;
                                else
                                    done_reg <= 1'b1;
                            end
                            tgdm_pkg::REQ_REFRESH:
                            begin
                                state_reg <= ST_REFRESH;
                            end
                            tgdm_pkg::REQ_CLEAR:
                            begin
                                report_reg <= 1'b1;
                                state_reg  <= ST_CLEAR;
                            end
                        endcase
                    end
                end
                ST_CLEAR:
                begin
                    if (cnt_reg == tgdm_pkg::CNT_W'(tgdm_pkg::DEPTH - 1))
                    begin
                        done_reg   <= report_reg;
                        report_reg <= 1'b0;
                        state_reg  <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + tgdm_pkg::CNT_W'(1);
                    end
                end
                ST_DECAY:
                begin
                    if (cnt_reg != '0)
                    begin
                        had_reg   <= had_reg | cell_nz;
                        after_reg <= after_reg | cell_stays;
                    end
                    if (cnt_reg == tgdm_pkg::CNT_W'(tgdm_pkg::DEPTH))
                    begin
                        expired_reg <= (had_reg | cell_nz) & ~(after_reg | cell_stays);
                        done_reg    <= 1'b1;
                        state_reg   <= ST_IDLE;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + tgdm_pkg::CNT_W'(1);
                    end
                end
                ST_STAMP_INIT:
                begin
                    r2_reg    <= sq;
                    x0_reg    <= x0_calc;
                    x1_reg    <= x1_calc;
                    y1_reg    <= y1_calc;
                    y_reg     <= y0_calc;
                    state_reg <= ST_ROW;
                end
                ST_ROW:
                begin
                    dy2_reg   <= sq;
                    x_reg     <= x0_reg;
                    state_reg <= ST_CELL;
                end
                ST_CELL:
                begin
                    if (x_reg == x1_reg)
                    begin
                        if (y_reg == y1_reg)
                        begin
                            done_reg  <= 1'b1;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            y_reg     <= y_reg + CW'(1);
                            state_reg <= ST_ROW;
                        end
                    end
                    else
                    begin
                        x_reg <= x_reg + CW'(1);
                    end
                end
                ST_REFRESH:
                begin
                    live_reg <= refresh_live;
                    if (enabled_reg && refresh_live && (master_reg < tgdm_pkg::LETHAL_COST))
                        cost_reg <= tgdm_pkg::LETHAL_COST;
                    else
                        cost_reg <= master_reg;
                    done_reg  <= 1'b1;
                    state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !mem_we)
        else $error("cell memory written while idle");

    a_result_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(live_reg && expired_reg))
        else $error("refresh and decay flags set in one result");

    a_refresh_read: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (req_type == tgdm_pkg::REQ_REFRESH)) |=> (state_reg == ST_REFRESH))
        else $error("refresh transaction did not start a cell read");

    a_cell_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CELL) |-> ((x_reg <= x1_reg) && (y_reg <= y1_reg)))
        else $error("stamp walk left its bounding box");

endmodule

FILE: bench/tb.sv
module tb;

    localparam int CYCLE_LIMIT = 8_000_000;
    localparam int SEG_ITEMS   = 12;
    localparam int NUM_SEGS    = 6;
    // the block decodes only three register indexes; the fourth must be ignored
    localparam logic [tgdm_pkg::IDX_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct {
        logic [tgdm_pkg::COST_W-1:0] cost;
        logic                        live;
        logic                        expired;
    } verdict_t;

    typedef struct {
        bit                          is_cfg;
        logic [tgdm_pkg::IDX_W-1:0]  idx;
        logic [tgdm_pkg::CFG_W-1:0]  data;
        tgdm_pkg::req_t              req;
        int                          x;
        int                          y;
        logic [tgdm_pkg::TTL_W-1:0]  dt;
        logic [tgdm_pkg::COST_W-1:0] cost;
        bit                          typed;
        verdict_t                    want;
    } stim_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          start;
    logic                          busy;
    logic [1:0]                    req_type;
    logic [6:0]                    cell_x;
    logic [6:0]                    cell_y;
    logic [tgdm_pkg::TTL_W-1:0]    elapsed_ms;
    logic [tgdm_pkg::COST_W-1:0]   master_cost;
    logic                          done;
    logic [tgdm_pkg::COST_W-1:0]   master_cost_out;
    logic                          cell_live;
    logic                          live_expired;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [tgdm_pkg::IDX_W-1:0]    cfg_index;
    logic [tgdm_pkg::CFG_W-1:0]    cfg_data;

    // shadow copy of the grid and its registers
    logic [tgdm_pkg::TTL_W-1:0]    ttl_cells [tgdm_pkg::DEPTH];
    logic [tgdm_pkg::TTL_W-1:0]    stamp_ttl;
    logic [tgdm_pkg::RAD_W-1:0]    stamp_radius;
    logic                          merge_enabled;

    verdict_t            pending_verdicts[$];
    stim_row_t           dir_rows[$];
    int                  stamp_cx[$];
    int                  stamp_cy[$];
    int                  fail_count;
    int                  cycle_count;
    int                  idle_pct;
    bit                  cur_typed;
    verdict_t            cur_want;

    ttl_grid_disk_marker dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .cell_x          (cell_x),
        .cell_y          (cell_y),
        .elapsed_ms      (elapsed_ms),
        .master_cost     (master_cost),
        .done            (done),
        .master_cost_out (master_cost_out),
        .cell_live       (cell_live),
        .live_expired    (live_expired),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb: FAIL");
        $finish;
    end

    task automatic flag_mismatch(input string what, input int got, input int want);
        $display("mismatch @%0t: %s got %0d want %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    function automatic int clip_coord(input int v);
        if (v < 0)
            return 0;
        if (v > 127)
            return 127;
        return v;
    endfunction

    // applies one transaction to the shadow grid and returns its expected result
    task automatic grid_apply(input tgdm_pkg::req_t rq, input int cx, input int cy,
                              input logic [tgdm_pkg::TTL_W-1:0] dt,
                              input logic [tgdm_pkg::COST_W-1:0] cost,
                              output verdict_t v);
        int k;
        int r;
        int x;
        int y;
        int x0;
        int x1;
        int y0;
        int y1;
        bit had;
        bit after;
        v.cost    = cost;
        v.live    = 1'b0;
        v.expired = 1'b0;
        case (rq)
            tgdm_pkg::REQ_DECAY:
            begin
                if (merge_enabled && dt != 0)
                begin
                    had   = 0;
                    after = 0;
                    for (k = 0; k < tgdm_pkg::DEPTH; k++)
                    begin
                        if (ttl_cells[k] != 0)
                            had = 1;
                        ttl_cells[k] = (ttl_cells[k] > dt) ? ttl_cells[k] - dt : '0;
                        if (ttl_cells[k] != 0)
                            after = 1;
                    end
                    v.expired = had && !after;
                end
            end
            tgdm_pkg::REQ_STAMP:
            begin
                r = int'(stamp_radius);
                if (merge_enabled && r != 0 && cx < tgdm_pkg::GRID_W && cy < tgdm_pkg::GRID_H)
                begin
                    x0 = (cx - r < 0) ? 0 : cx - r;
                    y0 = (cy - r < 0) ? 0 : cy - r;
                    x1 = (cx + r > tgdm_pkg::GRID_W - 1) ? tgdm_pkg::GRID_W - 1 : cx + r;
                    y1 = (cy + r > tgdm_pkg::GRID_H - 1) ? tgdm_pkg::GRID_H - 1 : cy + r;
                    for (y = y0; y <= y1; y++)
                        for (x = x0; x <= x1; x++)
                            if ((x - cx) * (x - cx) + (y - cy) * (y - cy) <= r * r)
                                ttl_cells[y * tgdm_pkg::GRID_W + x] = stamp_ttl;
                end
            end
            tgdm_pkg::REQ_REFRESH:
            begin
                if (cx < tgdm_pkg::GRID_W && cy < tgdm_pkg::GRID_H &&
                    ttl_cells[cy * tgdm_pkg::GRID_W + cx] != 0)
                    v.live = 1'b1;
                if (merge_enabled && v.live && cost < tgdm_pkg::LETHAL_COST)
                    v.cost = tgdm_pkg::LETHAL_COST;
            end
            default:
            begin
                for (k = 0; k < tgdm_pkg::DEPTH; k++)
                    ttl_cells[k] = '0;
            end
        endcase
    endtask

    always @(posedge clk)
    begin : monitor
        verdict_t want;
        verdict_t calc;
        if (rst_n)
        begin
            if (done)
            begin
                if (pending_verdicts.size() == 0)
                    flag_mismatch("result with nothing pending", 1, 0);
                else
                begin
                    want = pending_verdicts.pop_front();
                    if (master_cost_out !== want.cost)
                        flag_mismatch("master_cost_out", int'(master_cost_out),
                                      int'(want.cost));
                    if (cell_live !== want.live)
                        flag_mismatch("cell_live", int'(cell_live), int'(want.live));
                    if (live_expired !== want.expired)
                        flag_mismatch("live_expired", int'(live_expired), int'(want.expired));
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tgdm_pkg::CFG_TTL_MS:  stamp_ttl     = cfg_data[tgdm_pkg::TTL_W-1:0];
                    tgdm_pkg::CFG_RADIUS:  stamp_radius  = cfg_data[tgdm_pkg::RAD_W-1:0];
                    tgdm_pkg::CFG_ENABLED: merge_enabled = cfg_data[0];
                    default:     ;
                endcase
            end
            if (start && !busy)
            begin
                grid_apply(tgdm_pkg::req_t'(req_type), int'(cell_x), int'(cell_y),
                           elapsed_ms, master_cost, calc);
                pending_verdicts.push_back(cur_typed ? cur_want : calc);
            end
        end
    end

    // drops start so nothing new is taken, then waits for the block to go quiet
    task automatic drain();
        start <= 1'b0;
        while (pending_verdicts.size() != 0 || busy)
            @(negedge clk);
    endtask

    // leaves cfg_valid high; the caller lowers it before the next item
    task automatic write_reg(input logic [tgdm_pkg::IDX_W-1:0] idx,
                             input logic [tgdm_pkg::CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
    endtask

    task automatic send_item(input tgdm_pkg::req_t rq, input int x, input int y,
                             input logic [tgdm_pkg::TTL_W-1:0] dt,
                             input logic [tgdm_pkg::COST_W-1:0] cost,
                             input bit typed, input verdict_t want);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(negedge clk);
        end
        start       <= 1'b1;
        req_type    <= rq;
        cell_x      <= x[6:0];
        cell_y      <= y[6:0];
        elapsed_ms  <= dt;
        master_cost <= cost;
        cur_typed   <= typed;
        cur_want    <= want;
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    task automatic add_cfg(input logic [tgdm_pkg::IDX_W-1:0] idx,
                           input logic [tgdm_pkg::CFG_W-1:0] data);
        stim_row_t row;
        row = '{req: tgdm_pkg::REQ_DECAY, default: 0};
        row.is_cfg = 1;
        row.idx    = idx;
        row.data   = data;
        dir_rows.push_back(row);
    endtask

    task automatic add_item(input tgdm_pkg::req_t rq, input int x, input int y,
                            input logic [tgdm_pkg::TTL_W-1:0] dt,
                            input logic [tgdm_pkg::COST_W-1:0] cost,
                            input bit typed, input logic [tgdm_pkg::COST_W-1:0] c,
                            input logic l, input logic e);
        stim_row_t row;
        row = '{req: tgdm_pkg::REQ_DECAY, default: 0};
        row.req          = rq;
        row.x            = x;
        row.y            = y;
        row.dt           = dt;
        row.cost         = cost;
        row.typed        = typed;
        row.want.cost    = c;
        row.want.live    = l;
        row.want.expired = e;
        dir_rows.push_back(row);
    endtask

    initial
    begin : drive
        verdict_t                    no_want;
        tgdm_pkg::req_t              rq;
        int                          i;
        int                          seg;
        int                          n;
        int                          roll;
        int                          k;
        int                          span;
        int                          x;
        int                          y;
        logic [tgdm_pkg::TTL_W-1:0]  dt;
        logic [tgdm_pkg::COST_W-1:0] cost;
        logic [tgdm_pkg::TTL_W-1:0]  t_val;
        logic [tgdm_pkg::RAD_W-1:0]  r_val;
        logic                        e_val;

        rst_n       = 1'b0;
        start       = 1'b0;
        req_type    = tgdm_pkg::REQ_DECAY;
        cell_x      = '0;
        cell_y      = '0;
        elapsed_ms  = '0;
        master_cost = '0;
        cfg_valid   = 1'b0;
        cfg_index   = tgdm_pkg::CFG_TTL_MS;
        cfg_data    = '0;
        cur_typed   = 0;
        no_want     = '{default: 0};
        cur_want    = no_want;
        fail_count  = 0;
        idle_pct    = 12;
        for (i = 0; i < tgdm_pkg::DEPTH; i++)
            ttl_cells[i] = '0;
        stamp_ttl     = tgdm_pkg::TTL_RESET;
        stamp_radius  = tgdm_pkg::RAD_RESET;
        merge_enabled = 1'b1;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // reset defaults: ttl 300, radius 4, enabled
        add_item(tgdm_pkg::REQ_REFRESH, 0, 0, 0, 0, 1, 0, 0, 0);
        add_item(tgdm_pkg::REQ_DECAY, 5, 9, 100, 77, 1, 77, 0, 0);
        add_item(tgdm_pkg::REQ_STAMP, 64, 64, 0, 5, 1, 5, 0, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 64, 64, 0, 0, 1, tgdm_pkg::LETHAL_COST, 1, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 68, 64, 0, 253, 1, tgdm_pkg::LETHAL_COST, 1, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 68, 65, 0, 10, 1, 10, 0, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 64, 64, 0, 255, 1, 255, 1, 0);
        add_item(tgdm_pkg::REQ_DECAY, 0, 0, 0, 0, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_DECAY, 0, 0, 299, 0, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_DECAY, 0, 0, 1, 0, 0, 0, 0, 0);
        // largest disk, clipped at the corners
        add_cfg(tgdm_pkg::CFG_RADIUS, 16'hFFFF);
        add_item(tgdm_pkg::REQ_STAMP, 0, 0, 0, 8'hAA, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 44, 44, 0, 100, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 127, 127, 0, 0, 0, 0, 0, 0);
        add_cfg(tgdm_pkg::CFG_TTL_MS, 16'hFFFF);
        add_item(tgdm_pkg::REQ_STAMP, 127, 127, 16'hFFFF, 255, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 127, 127, 0, 1, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_DECAY, 127, 0, 16'hFFFF, 8'h55, 1, 8'h55, 0, 1);
        // disabled: live cell still reported, cost passes through, clear still works
        add_item(tgdm_pkg::REQ_STAMP, 64, 64, 0, 0, 0, 0, 0, 0);
        add_cfg(tgdm_pkg::CFG_ENABLED, 16'hFFFE);
        add_cfg(CFG_UNUSED, 16'hFFFF);
        add_item(tgdm_pkg::REQ_STAMP, 20, 20, 0, 0, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 64, 64, 0, 3, 1, 3, 1, 0);
        add_item(tgdm_pkg::REQ_DECAY, 0, 0, 5, 0, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_CLEAR, 0, 0, 0, 9, 1, 9, 0, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 64, 64, 0, 0, 1, 0, 0, 0);
        // zero ttl stamps dead cells; zero radius stamps nothing
        add_cfg(tgdm_pkg::CFG_ENABLED, 16'h0001);
        add_cfg(tgdm_pkg::CFG_TTL_MS, 16'h0000);
        add_item(tgdm_pkg::REQ_STAMP, 30, 30, 0, 0, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 30, 30, 0, 0, 0, 0, 0, 0);
        add_cfg(tgdm_pkg::CFG_RADIUS, 16'h0000);
        add_cfg(tgdm_pkg::CFG_TTL_MS, 16'd300);
        add_item(tgdm_pkg::REQ_STAMP, 40, 40, 0, 0, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_REFRESH, 40, 40, 0, 0, 0, 0, 0, 0);
        add_item(tgdm_pkg::REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
            begin
                drain();
                write_reg(dir_rows[i].idx, dir_rows[i].data);
            end
            else
            begin
                cfg_valid <= 1'b0;
                send_item(dir_rows[i].req, dir_rows[i].x, dir_rows[i].y, dir_rows[i].dt,
                          dir_rows[i].cost, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (seg = 0; seg < NUM_SEGS; seg++)
        begin
            drain();
            idle_pct = (seg < 2) ? 12 : (seg < 4) ? 84 : 0;
            case (seg)
                0:
                begin
                    t_val = tgdm_pkg::TTL_RESET;
                    r_val = tgdm_pkg::RAD_RESET;
                    e_val = 1'b1;
                end
                1: begin t_val = 16'd1; r_val = 6'd1; e_val = 1'b1; end
                2: begin t_val = 16'hFFFF; r_val = 6'd63; e_val = 1'b1; end
                3: begin t_val = 16'($urandom); r_val = 6'd0; e_val = 1'b1; end
                4:
                begin
                    t_val = 16'($urandom);
                    r_val = 6'($urandom_range(1, 12));
                    e_val = 1'b0;
                end
                default:
                begin
                    t_val = 16'($urandom_range(1, 2000));
                    r_val = 6'($urandom_range(2, 10));
                    e_val = 1'b1;
                end
            endcase
            write_reg(tgdm_pkg::CFG_TTL_MS, t_val);
            write_reg(tgdm_pkg::CFG_RADIUS, (16'($urandom) & 16'hFFC0) | 16'(r_val));
            write_reg(tgdm_pkg::CFG_ENABLED, (16'($urandom) & 16'hFFFE) | 16'(e_val));
            cfg_valid <= 1'b0;

            for (n = 0; n < SEG_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                x    = $urandom_range(127);
                y    = $urandom_range(127);
                dt   = 16'($urandom);
                cost = 8'($urandom);
                if (roll < 48)
                begin
                    rq = tgdm_pkg::REQ_REFRESH;
                    // mostly probe around recent disks so live cells get hit
                    if (stamp_cx.size() != 0 && $urandom_range(9) < 7)
                    begin
                        k    = $urandom_range(stamp_cx.size() - 1);
                        span = int'(stamp_radius) + 1;
                        x    = clip_coord(stamp_cx[k] + int'($urandom_range(2 * span)) - span);
                        y    = clip_coord(stamp_cy[k] + int'($urandom_range(2 * span)) - span);
                    end
                    if ($urandom_range(4) == 0)
                        cost = 8'(int'(tgdm_pkg::LETHAL_COST) - 1 + int'($urandom_range(2)));
                end
                else if (roll < 84)
                begin
                    rq = tgdm_pkg::REQ_STAMP;
                    if ($urandom_range(3) == 0)
                    begin
                        x = $urandom_range(1) ? 127 : 0;
                        y = $urandom_range(1) ? 127 : $urandom_range(127);
                    end
                    stamp_cx.push_back(x);
                    stamp_cy.push_back(y);
                    if (stamp_cx.size() > 8)
                    begin
                        void'(stamp_cx.pop_front());
                        void'(stamp_cy.pop_front());
                    end
                end
                else if (roll < 94)
                begin
                    rq = tgdm_pkg::REQ_DECAY;
                    case ($urandom_range(3))
                        0:       dt = '0;
                        1, 2:    dt = 16'($urandom_range(int'(stamp_ttl)));
                        default: ;
                    endcase
                end
                else
                    rq = tgdm_pkg::REQ_CLEAR;
                send_item(rq, x, y, dt, cost, 0, no_want);
            end
        end

        drain();
        repeat (20) @(negedge clk);
        if (fail_count == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
